FILE: hdl/vlrc_pkg.sv
// ----------------------------------------------------------------------------
// vlrc_pkg
// shared constants, codes and controller/datapath interface types of the
// versioned lru read cache controller
// ----------------------------------------------------------------------------
package vlrc_pkg;

  localparam int ENTRIES  = 1024;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int STORAGES = 16;
  localparam int SID_W    = 4;
  localparam int OFF_W    = 40;
  localparam int VER_W    = 16;
  localparam int RB_W     = 13;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 3;
  localparam int TAG_W    = SID_W + OFF_W + VER_W;

  localparam logic [RB_W-1:0] RB_RESET = RB_W'(48);

  // request codes
  localparam logic [REQ_W-1:0] REQ_READ    = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_STAGE   = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_COMMIT  = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_DROP    = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_DISCARD = REQ_W'(4);
  localparam logic [REQ_W-1:0] REQ_CLEAR   = REQ_W'(5);

  // result status codes
  localparam logic [STAT_W-1:0] ST_BYPASS = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_HIT    = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_MISS   = STAT_W'(2);
  localparam logic [STAT_W-1:0] ST_DONE   = STAT_W'(3);
  localparam logic [STAT_W-1:0] ST_ERROR  = STAT_W'(4);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_HIT_RD,
    S_HIT_UNLINK,
    S_HIT_APPEND,
    S_MISS_RD,
    S_MISS_EVICT,
    S_MISS_APPEND,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic link_rd;
    logic hit_unlink;
    logic hit_append;
    logic miss_evict;
    logic miss_append;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic bypass;
    logic match;
    logic scan_end;
    logic full;
    logic slot_newest;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/vlrc_ctrl.sv
// ----------------------------------------------------------------------------
// vlrc_ctrl
// request sequencer: steps the datapath through decode, tag scan, lru relink
// and result hand-off
// ----------------------------------------------------------------------------
module vlrc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vlrc_pkg::stat_t  stat,
  output vlrc_pkg::cmd_t   cmd
);

  vlrc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vlrc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vlrc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = vlrc_pkg::S_EXEC;
      end
      vlrc_pkg::S_EXEC: begin
        if (stat.is_read && !stat.bypass) state_nxt = vlrc_pkg::S_SCAN;
        else state_nxt = vlrc_pkg::S_RESP;
      end
      vlrc_pkg::S_SCAN: begin
        if (stat.match) state_nxt = vlrc_pkg::S_HIT_RD;
        else if (stat.scan_end) begin
          state_nxt = stat.full ? vlrc_pkg::S_MISS_RD : vlrc_pkg::S_MISS_APPEND;
        end
      end
      vlrc_pkg::S_HIT_RD: begin
        state_nxt = stat.slot_newest ? vlrc_pkg::S_RESP : vlrc_pkg::S_HIT_UNLINK;
      end
      vlrc_pkg::S_HIT_UNLINK:  state_nxt = vlrc_pkg::S_HIT_APPEND;
      vlrc_pkg::S_HIT_APPEND:  state_nxt = vlrc_pkg::S_RESP;
      vlrc_pkg::S_MISS_RD:     state_nxt = vlrc_pkg::S_MISS_EVICT;
      vlrc_pkg::S_MISS_EVICT:  state_nxt = vlrc_pkg::S_MISS_APPEND;
      vlrc_pkg::S_MISS_APPEND: state_nxt = vlrc_pkg::S_RESP;
      vlrc_pkg::S_RESP: begin
        if (stat.out_free) state_nxt = vlrc_pkg::S_IDLE;
      end
      default: state_nxt = vlrc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      vlrc_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      vlrc_pkg::S_EXEC:        cmd.exec = 1'b1;
      vlrc_pkg::S_SCAN:        cmd.scan = 1'b1;
      vlrc_pkg::S_HIT_RD:      cmd.link_rd = 1'b1;
      vlrc_pkg::S_HIT_UNLINK:  cmd.hit_unlink = 1'b1;
      vlrc_pkg::S_HIT_APPEND:  cmd.hit_append = 1'b1;
      vlrc_pkg::S_MISS_RD:     cmd.link_rd = 1'b1;
      vlrc_pkg::S_MISS_EVICT:  cmd.miss_evict = 1'b1;
      vlrc_pkg::S_MISS_APPEND: cmd.miss_append = 1'b1;
      vlrc_pkg::S_RESP:        cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hdl/vlrc_dp.sv
// ----------------------------------------------------------------------------
// vlrc_dp
// tag memory, lru link memories, per-storage state, staged record and the
// output register
// ----------------------------------------------------------------------------
module vlrc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [vlrc_pkg::RB_W-1:0]     cfg_wr_data,
  input  logic [vlrc_pkg::REQ_W-1:0]    in_req_type,
  input  logic [vlrc_pkg::SID_W-1:0]    in_storage_id,
  input  logic [vlrc_pkg::OFF_W-1:0]    in_seek_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vlrc_pkg::STAT_W-1:0]   out_status,
  output logic [vlrc_pkg::SLOT_W-1:0]   out_slot,
  output logic                          out_evicted,
  output logic [vlrc_pkg::OFF_W-1:0]    out_result_offset,
  input  vlrc_pkg::cmd_t                cmd,
  output vlrc_pkg::stat_t               stat
);

  localparam int SLOT_W = vlrc_pkg::SLOT_W;
  localparam int CNT_W  = vlrc_pkg::CNT_W;
  localparam int OFF_W  = vlrc_pkg::OFF_W;
  localparam int VER_W  = vlrc_pkg::VER_W;

  // memories
  logic [vlrc_pkg::TAG_W-1:0] tag_mem   [vlrc_pkg::ENTRIES];
  logic [SLOT_W-1:0]          older_mem [vlrc_pkg::ENTRIES];
  logic [SLOT_W-1:0]          newer_mem [vlrc_pkg::ENTRIES];

  // per-storage state
  logic [OFF_W-1:0] alloc_r [vlrc_pkg::STORAGES];
  logic [VER_W-1:0] ver_r   [vlrc_pkg::STORAGES];
  logic [vlrc_pkg::STORAGES-1:0] open_r;

  logic [vlrc_pkg::RB_W-1:0]   rb_r;
  logic                        staged_vld_r;
  logic [OFF_W-1:0]            staged_off_r;
  logic [vlrc_pkg::REQ_W-1:0]  req_r;
  logic [vlrc_pkg::SID_W-1:0]  sid_r;
  logic [OFF_W-1:0]            off_r;

  logic [SLOT_W-1:0] oldest_r, newest_r, slot_r;
  logic [CNT_W-1:0]  count_r, rd_idx_r;
  logic              cmp_vld_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic [vlrc_pkg::TAG_W-1:0] tag_q_r;
  logic [SLOT_W-1:0] older_q_r, newer_q_r;

  logic [vlrc_pkg::STAT_W-1:0] res_status_r;
  logic                        res_ev_r;
  logic [OFF_W-1:0]            res_off_r;

  logic [vlrc_pkg::TAG_W-1:0] key;
  logic [OFF_W-1:0]           cur_alloc;
  logic                       full, count_zero, slot_oldest, do_append;

  logic [vlrc_pkg::STAT_W-1:0] exec_status;
  logic [OFF_W-1:0]            exec_off;

  logic              older_we, newer_we;
  logic [SLOT_W-1:0] older_wa, older_wd, newer_wa, newer_wd;

  assign cur_alloc  = alloc_r[sid_r];
  assign key        = {sid_r, off_r, ver_r[sid_r]};
  assign full       = (count_r == CNT_W'(vlrc_pkg::ENTRIES));
  assign count_zero = (count_r == '0);
  assign slot_oldest = (slot_r == oldest_r);
  assign do_append  = cmd.hit_append || (cmd.miss_append && !count_zero);

  assign stat.is_read     = (req_r == vlrc_pkg::REQ_READ);
  assign stat.bypass      = staged_vld_r && (off_r == staged_off_r);
  assign stat.match       = cmp_vld_r && (tag_q_r == key);
  assign stat.scan_end    = !stat.match && (rd_idx_r == count_r);
  assign stat.full        = full;
  assign stat.slot_newest = (slot_r == newest_r);
  assign stat.out_free    = !out_valid || out_ready;

  // decode-time status and offset of the request
  always_comb begin
    exec_status = vlrc_pkg::ST_DONE;
    exec_off    = '0;
    unique case (req_r) inside
      vlrc_pkg::REQ_READ: begin
        if (stat.bypass) exec_status = vlrc_pkg::ST_BYPASS;
      end
      vlrc_pkg::REQ_STAGE: exec_off = cur_alloc;
      vlrc_pkg::REQ_COMMIT: begin
        if (!staged_vld_r || staged_off_r != cur_alloc) begin
          exec_status = vlrc_pkg::ST_ERROR;
        end else begin
          exec_off = cur_alloc;
        end
      end
      vlrc_pkg::REQ_DROP: begin
        if (!staged_vld_r) exec_status = vlrc_pkg::ST_ERROR;
      end
      vlrc_pkg::REQ_DISCARD, vlrc_pkg::REQ_CLEAR: ;
      default: exec_status = vlrc_pkg::ST_ERROR;
    endcase
  end

  // link memory write ports
  always_comb begin
    older_we = 1'b0;
    older_wa = slot_r;
    older_wd = newest_r;
    newer_we = 1'b0;
    newer_wa = newest_r;
    newer_wd = slot_r;
    if (cmd.hit_unlink && !slot_oldest) begin
      newer_we = 1'b1;
      newer_wa = older_q_r;
      newer_wd = newer_q_r;
      older_we = 1'b1;
      older_wa = newer_q_r;
      older_wd = older_q_r;
    end else if (do_append) begin
      older_we = 1'b1;
      newer_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (older_we) older_mem[older_wa] <= older_wd;
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    if (cmd.link_rd) begin
      older_q_r <= older_mem[slot_r];
      newer_q_r <= newer_mem[slot_r];
    end
    if (cmd.miss_append) tag_mem[slot_r] <= key;
    if (cmd.scan && !stat.match && (rd_idx_r < count_r)) begin
      tag_q_r <= tag_mem[rd_idx_r[SLOT_W-1:0]];
    end
  end

  // request capture, scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_req_type;
      sid_r <= in_storage_id;
      off_r <= in_seek_offset;
    end
    if (cmd.exec) begin
      slot_r       <= '0;
      res_ev_r     <= 1'b0;
      res_off_r    <= exec_off;
      res_status_r <= exec_status;
      rd_idx_r     <= '0;
    end
    if (cmd.scan) begin
      if (stat.match) begin
        slot_r       <= cmp_idx_r;
        res_status_r <= vlrc_pkg::ST_HIT;
      end else if (stat.scan_end) begin
        slot_r       <= full ? oldest_r : count_r[SLOT_W-1:0];
        res_ev_r     <= full;
        res_status_r <= vlrc_pkg::ST_MISS;
        res_off_r    <= off_r;
      end else begin
        cmp_idx_r <= rd_idx_r[SLOT_W-1:0];
        rd_idx_r  <= rd_idx_r + CNT_W'(1);
      end
    end
    if (cmd.load_out) begin
      out_status        <= res_status_r;
      out_slot          <= slot_r;
      out_evicted       <= res_ev_r;
      out_result_offset <= res_off_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r         <= vlrc_pkg::RB_RESET;
      staged_vld_r <= 1'b0;
      staged_off_r <= '0;
      open_r       <= '0;
      oldest_r     <= '0;
      newest_r     <= '0;
      count_r      <= '0;
      cmp_vld_r    <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < vlrc_pkg::STORAGES; i++) begin
        alloc_r[i] <= '0;
        ver_r[i]   <= '0;
      end
    end else begin
      if (cfg_wr_en) rb_r <= cfg_wr_data;
      if (cmd.exec) begin
        cmp_vld_r <= 1'b0;
        unique case (req_r)
          vlrc_pkg::REQ_STAGE: begin
            staged_vld_r <= 1'b1;
            staged_off_r <= cur_alloc;
          end
          vlrc_pkg::REQ_COMMIT: begin
            if (staged_vld_r && staged_off_r == cur_alloc) begin
              open_r[sid_r]  <= 1'b1;
              staged_vld_r   <= 1'b0;
              alloc_r[sid_r] <= cur_alloc + OFF_W'(rb_r);
            end
          end
          vlrc_pkg::REQ_DROP: begin
            if (staged_vld_r) begin
              staged_vld_r <= 1'b0;
              staged_off_r <= '0;
            end
          end
          vlrc_pkg::REQ_DISCARD: begin
            if (open_r[sid_r]) begin
              open_r[sid_r]  <= 1'b0;
              alloc_r[sid_r] <= '0;
              ver_r[sid_r]   <= ver_r[sid_r] + VER_W'(1);
            end
          end
          vlrc_pkg::REQ_CLEAR: begin
            count_r  <= '0;
            oldest_r <= '0;
            newest_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.scan) cmp_vld_r <= !stat.match && (rd_idx_r < count_r);
      if (cmd.hit_unlink && slot_oldest) oldest_r <= newer_q_r;
      if (cmd.hit_append) newest_r <= slot_r;
      if (cmd.miss_evict) begin
        oldest_r <= newer_q_r;
        count_r  <= count_r - CNT_W'(1);
      end
      if (cmd.miss_append) begin
        if (count_zero) oldest_r <= slot_r;
        newest_r <= slot_r;
        count_r  <= count_r + CNT_W'(1);
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/versioned_lru_read_cache_controller.sv
// ----------------------------------------------------------------------------
// versioned_lru_read_cache_controller
// tag and lru policy controller of a 1024-entry fully associative read cache
// keyed by storage id, byte offset and storage version
// ----------------------------------------------------------------------------
// One request is worked at a time and every request gives exactly one result
// beat. Stage, commit, drop, discard, clear, unknown codes and staged bypass
// reads go from accept through decode to the result hand-off. Other reads scan
// the tag memory one entry per cycle from slot 0 up to the fill count. A hit
// reads the lru links of its slot and, unless it is already newest, relinks it
// as newest; a miss reads the links of the oldest entry and evicts it when the
// cache is full, then writes its tag and appends it as newest. The single read
// port of the tag memory sets the scan rate. The result register holds a
// finished beat while the output side stalls; a new request is taken once that
// beat has been loaded. Clear takes effect at once through the fill count, no
// sweep. record_bytes may be written only while the block is idle.
module versioned_lru_read_cache_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [vlrc_pkg::RB_W-1:0]         cfg_wr_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vlrc_pkg::REQ_W-1:0]        in_req_type,
  input  logic [vlrc_pkg::SID_W-1:0]        in_storage_id,
  input  logic [vlrc_pkg::OFF_W-1:0]        in_seek_offset,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vlrc_pkg::STAT_W-1:0]       out_status,
  output logic [vlrc_pkg::SLOT_W-1:0]       out_slot,
  output logic                              out_evicted,
  output logic [vlrc_pkg::OFF_W-1:0]        out_result_offset
);

  // command and status between sequencer and datapath
  vlrc_pkg::cmd_t  cmd;
  vlrc_pkg::stat_t stat;

  vlrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories, pointers, per-storage state and the result register
  vlrc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_storage_id     (in_storage_id),
    .in_seek_offset    (in_seek_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_evicted       (out_evicted),
    .out_result_offset (out_result_offset),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

FILE: hdl/vlrc_checker.sv
// ----------------------------------------------------------------------------
// vlrc_checker
// port-level checks of the cache controller, bound to the top level
// ----------------------------------------------------------------------------
module vlrc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [vlrc_pkg::STAT_W-1:0]       out_status,
  input logic [vlrc_pkg::SLOT_W-1:0]       out_slot,
  input logic                              out_evicted
);

  // a held result beat keeps its status and slot
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("result beat changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // eviction only reported with a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_status == vlrc_pkg::ST_MISS)
    else $error("eviction flagged without a miss");

  // status codes stay in range, and bypass beats carry no slot
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == vlrc_pkg::ST_BYPASS && out_slot == '0) ||
                  out_status == vlrc_pkg::ST_HIT || out_status == vlrc_pkg::ST_MISS ||
                  out_status == vlrc_pkg::ST_DONE || out_status == vlrc_pkg::ST_ERROR)
    else $error("bad result status");

endmodule

bind versioned_lru_read_cache_controller vlrc_checker u_vlrc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_status  (out_status),
  .out_slot    (out_slot),
  .out_evicted (out_evicted)
);

FILE: verif/tb_versioned_lru_read_cache_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_versioned_lru_read_cache_controller
// self-checking bench for the versioned lru read cache controller: requests
// are mirrored into a cycle-free shadow of the tag store, lru chain, staged
// record and per-storage offsets/versions; each result beat is compared in
// order against the shadow's answer under random idling on both channels
// ----------------------------------------------------------------------------
module tb_versioned_lru_read_cache_controller;

  // reserved request codes, expected to give an error
  localparam logic [vlrc_pkg::REQ_W-1:0] REQ_RSVD_LO = vlrc_pkg::REQ_W'(6);
  localparam logic [vlrc_pkg::REQ_W-1:0] REQ_RSVD_HI = vlrc_pkg::REQ_W'(7);
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [vlrc_pkg::REQ_W-1:0] req;
    logic [vlrc_pkg::SID_W-1:0] sid;
    logic [vlrc_pkg::OFF_W-1:0] off;
  } request_t;

  typedef struct packed {
    logic [vlrc_pkg::STAT_W-1:0] status;
    logic [vlrc_pkg::SLOT_W-1:0] slot;
    logic                        evicted;
    logic [vlrc_pkg::OFF_W-1:0]  roff;
  } result_t;

  // shadow of the cache state plus the queue of answers still owed
  class cache_scoreboard;
    bit                          tag_valid [vlrc_pkg::ENTRIES];
    logic [vlrc_pkg::SID_W-1:0]  tag_sid   [vlrc_pkg::ENTRIES];
    logic [vlrc_pkg::OFF_W-1:0]  tag_off   [vlrc_pkg::ENTRIES];
    logic [vlrc_pkg::VER_W-1:0]  tag_ver   [vlrc_pkg::ENTRIES];
    int                          older     [vlrc_pkg::ENTRIES];
    int                          newer     [vlrc_pkg::ENTRIES];
    int                          oldest, newest, fill;
    logic [vlrc_pkg::OFF_W-1:0]  alloc     [vlrc_pkg::STORAGES];
    logic [vlrc_pkg::VER_W-1:0]  version   [vlrc_pkg::STORAGES];
    bit                          is_open   [vlrc_pkg::STORAGES];
    bit                          staged;
    logic [vlrc_pkg::OFF_W-1:0]  staged_off;
    logic [vlrc_pkg::RB_W-1:0]   rec_bytes;
    result_t                     owed[$];
    int                          errors, beats;
    int                          status_seen [8];

    function new();
      rec_bytes = vlrc_pkg::RB_RESET;
      oldest = 0; newest = 0; fill = 0;
      staged = 0; staged_off = '0;
      errors = 0; beats = 0;
      foreach (tag_valid[i]) tag_valid[i] = 0;
      foreach (alloc[i]) begin
        alloc[i] = '0; version[i] = '0; is_open[i] = 0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function int lookup(logic [vlrc_pkg::SID_W-1:0] sid, logic [vlrc_pkg::OFF_W-1:0] off);
      for (int i = 0; i < fill; i++)
        if (tag_valid[i] && tag_sid[i] == sid && tag_off[i] == off &&
            tag_ver[i] == version[sid])
          return i;
      return -1;
    endfunction

    function void append_newest(int s);
      if (fill == 0) oldest = s;
      else begin
        older[s] = newest;
        newer[newest] = s;
      end
      newest = s;
    endfunction

    function void unlink(int s);
      if (s == oldest) oldest = newer[s];
      else begin
        newer[older[s]] = newer[s];
        older[newer[s]] = older[s];
      end
    endfunction

    function void note_request(request_t r);
      result_t e;
      int f;
      int s;
      e = '{status: vlrc_pkg::ST_DONE, slot: '0, evicted: 1'b0, roff: '0};
      case (r.req)
        vlrc_pkg::REQ_READ: begin
          if (staged && r.off == staged_off) e.status = vlrc_pkg::ST_BYPASS;
          else begin
            f = lookup(r.sid, r.off);
            if (f >= 0) begin
              if (f != newest) begin
                unlink(f);
                append_newest(f);
              end
              e.status = vlrc_pkg::ST_HIT;
              e.slot = vlrc_pkg::SLOT_W'(f);
            end else begin
              if (fill >= vlrc_pkg::ENTRIES) begin
                s = oldest;
                unlink(s);
                fill--;
                e.evicted = 1'b1;
              end else s = fill;
              tag_valid[s] = 1;
              tag_sid[s] = r.sid;
              tag_off[s] = r.off;
              tag_ver[s] = version[r.sid];
              append_newest(s);
              fill++;
              e.status = vlrc_pkg::ST_MISS;
              e.slot = vlrc_pkg::SLOT_W'(s);
              e.roff = r.off;
            end
          end
        end
        vlrc_pkg::REQ_STAGE: begin
          staged = 1;
          staged_off = alloc[r.sid];
          e.roff = staged_off;
        end
        vlrc_pkg::REQ_COMMIT: begin
          if (!staged || staged_off != alloc[r.sid]) e.status = vlrc_pkg::ST_ERROR;
          else begin
            is_open[r.sid] = 1;
            staged = 0;
            e.roff = alloc[r.sid];
            alloc[r.sid] = alloc[r.sid] + vlrc_pkg::OFF_W'(rec_bytes);
          end
        end
        vlrc_pkg::REQ_DROP: begin
          if (!staged) e.status = vlrc_pkg::ST_ERROR;
          else begin
            staged = 0;
            staged_off = '0;
          end
        end
        vlrc_pkg::REQ_DISCARD: begin
          if (is_open[r.sid]) begin
            is_open[r.sid] = 0;
            alloc[r.sid] = '0;
            version[r.sid] = version[r.sid] + vlrc_pkg::VER_W'(1);
          end
        end
        vlrc_pkg::REQ_CLEAR: begin
          foreach (tag_valid[i]) tag_valid[i] = 0;
          fill = 0; oldest = 0; newest = 0;
        end
        default: e.status = vlrc_pkg::ST_ERROR;
      endcase
      owed.push_back(e);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, got);
        errors++;
        return;
      end
      e = owed[0];
      owed.delete(0);
      beats++;
      status_seen[got.status]++;
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.slot !== e.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, e.slot, got.slot);
        errors++;
      end
      if (got.evicted !== e.evicted) begin
        $display("%0t: evicted expected %0b actual %0b", $time, e.evicted, got.evicted);
        errors++;
      end
      if (got.roff !== e.roff) begin
        $display("%0t: result_offset expected %h actual %h", $time, e.roff, got.roff);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [vlrc_pkg::RB_W-1:0]   cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [vlrc_pkg::REQ_W-1:0]  in_req_type = '0;
  logic [vlrc_pkg::SID_W-1:0]  in_storage_id = '0;
  logic [vlrc_pkg::OFF_W-1:0]  in_seek_offset = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [vlrc_pkg::STAT_W-1:0] out_status;
  logic [vlrc_pkg::SLOT_W-1:0] out_slot;
  logic                        out_evicted;
  logic [vlrc_pkg::OFF_W-1:0]  out_result_offset;

  cache_scoreboard sb = new();
  int sender_idle_pct = 17;
  int receiver_idle_pct = 60;
  int sent = 0;
  int cycles = 0;

  // recently read keys, replayed to provoke hits
  logic [vlrc_pkg::SID_W-1:0] recent_sid [32];
  logic [vlrc_pkg::OFF_W-1:0] recent_off [32];
  int recent_cnt = 0;

  versioned_lru_read_cache_controller i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_storage_id    (in_storage_id),
    .in_seek_offset   (in_seek_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_evicted      (out_evicted),
    .out_result_offset(out_result_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls at random, ready changes only on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // result beats are compared in arrival order
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{status: out_status, slot: out_slot, evicted: out_evicted,
                        roff: out_result_offset});
  end

  // present one request beat; called and returns at a falling edge
  task automatic send(logic [vlrc_pkg::REQ_W-1:0] req, logic [vlrc_pkg::SID_W-1:0] sid,
                      logic [vlrc_pkg::OFF_W-1:0] off);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_storage_id  <= sid;
    in_seek_offset <= off;
    do @(posedge clk); while (!in_ready);
    sb.note_request('{req: req, sid: sid, off: off});
    sent++;
    if (req == vlrc_pkg::REQ_READ) begin
      recent_sid[recent_cnt % 32] = sid;
      recent_off[recent_cnt % 32] = off;
      recent_cnt++;
    end
    @(negedge clk);
  endtask

  // wait until every owed beat is back, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_record_bytes(logic [vlrc_pkg::RB_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.rec_bytes = v;
  endtask

  function automatic logic [vlrc_pkg::OFF_W-1:0] rand_off();
    return vlrc_pkg::OFF_W'({$urandom(), $urandom()});
  endfunction

  task automatic directed();
    send(vlrc_pkg::REQ_CLEAR, 4'd0, '0);
    send(vlrc_pkg::REQ_READ, 4'd0, '0);                 // miss into slot 0
    send(vlrc_pkg::REQ_READ, 4'd0, '0);                 // hit on newest
    send(vlrc_pkg::REQ_READ, 4'd15, '1);                // miss, top offset
    send(vlrc_pkg::REQ_READ, 4'd0, '0);                 // hit that relinks
    send(vlrc_pkg::REQ_STAGE, 4'd3, rand_off());        // handle 0
    send(vlrc_pkg::REQ_READ, 4'd9, '0);                 // bypass from another storage
    send(vlrc_pkg::REQ_STAGE, 4'd3, '0);                // restage overwrites
    send(vlrc_pkg::REQ_COMMIT, 4'd3, '0);
    send(vlrc_pkg::REQ_COMMIT, 4'd3, '0);               // nothing staged
    send(vlrc_pkg::REQ_DROP, 4'd3, '0);                 // drop with nothing staged
    send(vlrc_pkg::REQ_STAGE, 4'd3, '0);
    send(vlrc_pkg::REQ_COMMIT, 4'd5, '0);               // staged offset != alloc offset
    send(vlrc_pkg::REQ_DROP, 4'd3, '0);
    send(vlrc_pkg::REQ_DISCARD, 4'd3, '0);              // open storage, version bump
    send(vlrc_pkg::REQ_DISCARD, 4'd7, '0);              // closed storage, no effect
    send(vlrc_pkg::REQ_READ, 4'd3, '0);                 // new version, misses
    send(REQ_RSVD_LO, 4'd1, '1);
    send(REQ_RSVD_HI, 4'd14, '0);
    send(vlrc_pkg::REQ_READ, 4'd9, 40'h5555555555);     // closed storage read
    send(vlrc_pkg::REQ_CLEAR, 4'd0, '0);
    send(vlrc_pkg::REQ_READ, 4'd3, '0);                 // refills at slot 0
  endtask

  // mostly well-formed record flows with random content, some noise
  task automatic random_traffic(int n);
    int stop;
    int k;
    int j;
    logic [vlrc_pkg::SID_W-1:0] sid;
    logic [vlrc_pkg::OFF_W-1:0] off;
    stop = sent + n;
    while (sent < stop) begin
      k = $urandom_range(99);
      sid = vlrc_pkg::SID_W'($urandom_range(15));
      if (k < 8) send(vlrc_pkg::REQ_W'($urandom_range(7)), sid, rand_off());
      else if (k < 10) send(vlrc_pkg::REQ_CLEAR, sid, rand_off());
      else if (k < 40 && recent_cnt > 0) begin
        j = $urandom_range((recent_cnt < 32 ? recent_cnt : 32) - 1);
        send(vlrc_pkg::REQ_READ, recent_sid[j], recent_off[j]);
      end else if (k < 55) begin
        off = $urandom_range(1) ? rand_off() :
              vlrc_pkg::OFF_W'($urandom_range(63) * sb.rec_bytes);
        send(vlrc_pkg::REQ_READ, sid, off);
      end else if (k < 70) begin
        off = sb.alloc[sid];
        send(vlrc_pkg::REQ_STAGE, sid, rand_off());
        send(vlrc_pkg::REQ_COMMIT,
             $urandom_range(4) == 0 ? vlrc_pkg::SID_W'($urandom_range(15)) : sid,
             rand_off());
        send(vlrc_pkg::REQ_READ, sid, off);
      end else if (k < 80) begin
        send(vlrc_pkg::REQ_STAGE, sid, rand_off());
        send(vlrc_pkg::REQ_READ, vlrc_pkg::SID_W'($urandom_range(15)), sb.staged_off);
        send($urandom_range(1) ? vlrc_pkg::REQ_DROP : vlrc_pkg::REQ_COMMIT, sid,
             rand_off());
      end else if (k < 88) send(vlrc_pkg::REQ_DISCARD, sid, rand_off());
      else if (recent_cnt > 0) begin
        j = $urandom_range((recent_cnt < 32 ? recent_cnt : 32) - 1);
        send(vlrc_pkg::REQ_READ, sid, recent_off[j]);   // same offset, any storage
      end
    end
  endtask

  // fill every slot, then force evictions and relinks of old entries
  task automatic fill_and_evict();
    send(vlrc_pkg::REQ_CLEAR, 4'd0, '0);
    for (int i = 0; i < 1080; i++) begin
      send(vlrc_pkg::REQ_READ, vlrc_pkg::SID_W'(i), vlrc_pkg::OFF_W'(i * 8));
      if (i > 600 && i % 97 == 0)
        send(vlrc_pkg::REQ_READ, vlrc_pkg::SID_W'(i - 300), vlrc_pkg::OFF_W'((i - 300) * 8));
    end
    send(vlrc_pkg::REQ_READ, 4'd0, '0);                 // long gone, evicts again
    send(vlrc_pkg::REQ_CLEAR, 4'd0, '0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender idles rarely, receiver often
    directed();
    settle();
    write_record_bytes(vlrc_pkg::RB_W'(4096));
    random_traffic(250);
    settle();

    // phase 2: roles swapped, smallest and zero record sizes
    sender_idle_pct = 60;
    receiver_idle_pct = 17;
    write_record_bytes(vlrc_pkg::RB_W'(1));
    random_traffic(150);
    settle();
    write_record_bytes(vlrc_pkg::RB_W'(0));
    random_traffic(50);
    settle();

    // phase 3: no idling, full cache with evictions, all-ones size
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_record_bytes('1);
    fill_and_evict();
    random_traffic(250);
    settle();

    $display("covered %0d requests, %0d result beats, record sizes 48/4096/1/0/8191",
             sent, sb.beats);
    $display("bypass %0d hit %0d miss %0d done %0d error %0d",
             sb.status_seen[vlrc_pkg::ST_BYPASS], sb.status_seen[vlrc_pkg::ST_HIT],
             sb.status_seen[vlrc_pkg::ST_MISS], sb.status_seen[vlrc_pkg::ST_DONE],
             sb.status_seen[vlrc_pkg::ST_ERROR]);
    if (sb.errors == 0 && sb.pending() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/vlrc_pkg.sv
hdl/vlrc_ctrl.sv
hdl/vlrc_dp.sv
hdl/versioned_lru_read_cache_controller.sv
hdl/vlrc_checker.sv
verif/tb_versioned_lru_read_cache_controller.sv
